// File: rtl/e2g_pkg.sv
package e2g_pkg;

	// sizes
	localparam int CORDIC_STAGES       = 32;
	localparam int ANGLE_FRACTION_BITS = 24;
	localparam int GUARD_BITS          = 20;
	localparam int UNIT_BITS           = 52;
	localparam int QB                  = 30;
	localparam int IN_W                = 34;
	localparam int DW                  = 58;
	localparam int AW                  = 57;
	localparam int RW                  = 32;
	localparam int BW                  = 33;
	localparam int LAT_W               = 32;
	localparam int LON_W               = 33;

	// ellipsoid semi-axes in micrometers
	localparam logic [63:0] SEMI_MAJOR_UM = 64'd6378137000000;
	localparam logic [63:0] SEMI_MINOR_UM = 64'd6356752314245;

	typedef logic signed [DW-1:0] data_t;
	typedef logic signed [AW-1:0] ang_t;
	typedef logic signed [RW-1:0] rot_t;
	typedef logic signed [BW-1:0] coef_t;
	typedef ang_t atan_tab_t [CORDIC_STAGES];

	// values carried beside a cordic
	typedef struct packed {
		data_t pk;
		data_t zk;
		ang_t  lon;
	} side_t;

	// result word, latitude in the low bits
	typedef struct packed {
		logic signed [LON_W-1:0] lon;
		logic signed [LAT_W-1:0] lat;
	} res_t;

	// restoring long division, quotient in the upper half
	function automatic logic [127:0] udivmod(input logic [63:0] n, input logic [63:0] d);
		logic [63:0] q;
		logic [63:0] r;
		q = '0;
		r = '0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[62:0], n[i]};
			if (r >= d) begin
				r = r - d;
				q[i] = 1'b1;
			end
		end
		return {q, r};
	endfunction

	function automatic logic [63:0] udiv_q(input logic [63:0] n, input logic [63:0] d);
		logic [127:0] qr;
		qr = udivmod(n, d);
		return qr[127:64];
	endfunction

	function automatic logic [63:0] udiv_r(input logic [63:0] n, input logic [63:0] d);
		logic [127:0] qr;
		qr = udivmod(n, d);
		return qr[63:0];
	endfunction

	// floor(num * 2^bits / den)
	function automatic logic [63:0] frac_div(input logic [63:0] num, input logic [63:0] den,
			input int bits);
		logic [63:0] q;
		logic [63:0] r;
		q = udiv_q(num, den);
		r = udiv_r(num, den);
		for (int i = 0; i < bits; i++) begin
			q = q << 1;
			r = r << 1;
			if (r >= den) begin
				r = r - den;
				q = q | 64'd1;
			end
		end
		return q;
	endfunction

	function automatic logic [63:0] isqrt64(input logic [63:0] v0);
		logic [63:0] v;
		logic [63:0] res;
		logic [63:0] b;
		v = v0;
		res = '0;
		b = 64'd1 << 62;
		for (int i = 0; i < 32; i++)
			if (b > v) b = b >> 2;
		for (int i = 0; i < 32; i++) begin
			if (b != 0) begin
				if (v >= res + b) begin
					v = v - (res + b);
					res = (res >> 1) + b;
				end else begin
					res = res >> 1;
				end
				b = b >> 2;
			end
		end
		return res;
	endfunction

	// atan(1/n) in q62
	function automatic logic signed [63:0] atan_recip(input logic [63:0] n);
		logic [63:0] pw;
		logic [63:0] n2;
		logic [63:0] k;
		logic signed [63:0] sum;
		logic signed [63:0] t;
		pw = udiv_q(64'd1 << 62, n);
		n2 = n * n;
		k = '0;
		sum = '0;
		for (int it = 0; it < 64; it++) begin
			if (pw != 0) begin
				t = udiv_q(pw, 2 * k + 1);
				sum = k[0] ? sum - t : sum + t;
				pw = udiv_q(pw, n2);
				k = k + 1;
			end
		end
		return sum;
	endfunction

	// atan(2^-i) in q62
	function automatic logic signed [63:0] atan_pow2(input int i);
		logic signed [63:0] sum;
		logic signed [63:0] t;
		int e;
		sum = '0;
		for (int k = 0; k < 32; k++) begin
			e = i * (2 * k + 1);
			if (e <= 62) begin
				t = udiv_q(64'd1 << (62 - e), 64'(2 * k + 1));
				sum = k[0] ? sum - t : sum + t;
			end
		end
		return sum;
	endfunction

	function automatic atan_tab_t build_atan();
		atan_tab_t tab;
		logic [63:0] quarter;
		logic [63:0] f;
		quarter = 4 * atan_recip(64'd5) - atan_recip(64'd239);
		for (int i = 0; i < CORDIC_STAGES; i++) begin
			if (i == 0) begin
				tab[i] = ang_t'(64'd1 << UNIT_BITS);
			end else begin
				f = frac_div(atan_pow2(i), quarter, UNIT_BITS + 1);
				tab[i] = ang_t'((f + 64'd1) >> 1);
			end
		end
		return tab;
	endfunction

	// cordic gain in q30
	function automatic logic [63:0] calc_k();
		logic [63:0] g;
		g = 64'd1 << 60;
		for (int i = 0; i < CORDIC_STAGES; i++)
			if (2 * i < 64) g = g + (g >> (2 * i));
		return isqrt64(g);
	endfunction

	// floor(a * b / 2^30) for positive operands
	function automatic logic [63:0] mulq_c(input logic [63:0] a, input logic [63:0] b);
		return (a >> QB) * b + (((a & 64'h3FFF_FFFF) * b) >> QB);
	endfunction

	localparam logic [63:0] K_RAW     = calc_k();
	localparam logic [63:0] INV_K_RAW = udiv_q(64'd1 << 60, K_RAW);
	localparam logic [63:0] BA_RAW    = frac_div(SEMI_MINOR_UM, SEMI_MAJOR_UM, QB);
	localparam logic [63:0] DG_RAW    =
		udiv_q((SEMI_MAJOR_UM - SEMI_MINOR_UM) << GUARD_BITS, 64'd1000);
	localparam logic [63:0] CA_RAW    = mulq_c(mulq_c(DG_RAW,
		frac_div(SEMI_MAJOR_UM + SEMI_MINOR_UM, SEMI_MAJOR_UM, QB)), K_RAW);
	localparam logic [63:0] CB_RAW    = mulq_c(mulq_c(DG_RAW,
		frac_div(SEMI_MAJOR_UM + SEMI_MINOR_UM, SEMI_MINOR_UM, QB)), K_RAW);

	localparam coef_t     K_Q30     = coef_t'(K_RAW);
	localparam rot_t      INV_K_Q30 = rot_t'(INV_K_RAW);
	localparam coef_t     BA_Q30    = coef_t'(BA_RAW);
	localparam data_t     CORR_A    = data_t'(CA_RAW);
	localparam data_t     CORR_B    = data_t'(CB_RAW);
	localparam atan_tab_t ATAN_TAB  = build_atan();

endpackage

// File: rtl/ecef_to_geodetic.sv
// throughput: one request per cycle while the output buffer is not both full and stalled,
// set by the fully unrolled cordic and multiplier stages
// a two-entry output buffer keeps the pipeline moving while one result waits
// reset: asynchronous active low, clears all valid bits and the output buffer
module ecef_to_geodetic (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [103:0] s_tdata,   // pos_x_mm[33:0], pos_y_mm[67:34], pos_z_mm[101:68]
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [71:0]  m_tdata    // latitude_deg[31:0], longitude_deg[64:32]
);
	import e2g_pkg::*;

	localparam int N = CORDIC_STAGES;
	localparam int DS = UNIT_BITS - ANGLE_FRACTION_BITS;
	localparam logic signed [63:0] LAT_LIM64 = 64'sd90 <<< ANGLE_FRACTION_BITS;
	localparam logic signed [63:0] LON_LIM64 = 64'sd180 <<< ANGLE_FRACTION_BITS;
	localparam logic signed [LAT_W-1:0] LAT_LIM = LAT_W'(LAT_LIM64);
	localparam logic signed [LON_W-1:0] LON_LIM = LON_W'(LON_LIM64);

	function automatic logic signed [63:0] to_deg(input ang_t a, input logic signed [63:0] lim);
		logic signed [63:0] ae;
		logic signed [63:0] d;
		ae = 64'(a);
		d = (ae * 64'sd45 + (64'sd1 <<< (DS - 1))) >>> DS;
		if (d > lim) d = lim;
		if (d < -lim) d = -lim;
		return d;
	endfunction

	logic en;
	logic push;
	logic pop;
	logic [1:0] cnt_q;
	res_t buf0_q;
	res_t buf1_q;
	res_t res;

	logic  v_s1;
	data_t x_s1, y_s1, z_s1;
	side_t side1;

	logic  v_a;
	data_t pk_a;
	ang_t  lon_a;
	side_t sa;

	logic  v_m_s1, v_m_s2;
	data_t pk_m_s1, pk_m_s2;
	ang_t  lon_m_s1, lon_m_s2;
	data_t pb_m, zk_m;
	side_t side2;

	logic  v_q;
	ang_t  q_ang;
	side_t q_side;

	logic [N:0] rv_s;
	rot_t  rx_s [0:N];
	rot_t  ry_s [0:N];
	ang_t  ra_s [0:N];
	side_t rsd_s [0:N];

	logic  v_c_s1, v_c_s2;
	logic signed [2*RW-1:0] sqc_s1, sqs_s1;
	rot_t  c_s1, s_s1;
	side_t sd_c_s1, sd_c_s2;
	logic signed [2*RW+1:0] tc_s2, ts_s2;
	coef_t cube_c, cube_s;

	logic  v_n_s1, v_n_s2;
	side_t sd_n_s1, sd_n_s2;
	data_t ma, mb;

	logic  v_d_s1;
	data_t num_s1, den_s1;
	ang_t  lon_d_s1;
	side_t side3;

	logic  v_l;
	ang_t  lat_ang;
	side_t sl;

	// pipeline moves unless the output buffer is full and stalled
	assign en = (cnt_q != 2'd2) || m_tready;
	assign s_tready = en;

	// input stage: sign extend and scale
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= data_t'($signed(s_tdata[IN_W-1:0])) <<< GUARD_BITS;
			y_s1 <= data_t'($signed(s_tdata[2*IN_W-1:IN_W])) <<< GUARD_BITS;
			z_s1 <= data_t'($signed(s_tdata[3*IN_W-1:2*IN_W])) <<< GUARD_BITS;
		end
	end

	// longitude and scaled p
	assign side1 = '{pk: '0, zk: z_s1, lon: '0};

	e2g_vec u_vec_lon (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.vin      (v_s1),
		.xin      (x_s1),
		.yin      (y_s1),
		.side_in  (side1),
		.vout     (v_a),
		.len      (pk_a),
		.ang      (lon_a),
		.side_out (sa)
	);

	// p * b/a and z * k
	e2g_mulq u_mul_pb (.clk(clk), .en(en), .a(pk_a), .b(BA_Q30), .p(pb_m));
	e2g_mulq u_mul_zk (.clk(clk), .en(en), .a(sa.zk), .b(K_Q30), .p(zk_m));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_m_s1 <= 1'b0;
			v_m_s2 <= 1'b0;
		end else if (en) begin
			v_m_s1 <= v_a;
			v_m_s2 <= v_m_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pk_m_s1  <= pk_a;
			pk_m_s2  <= pk_m_s1;
			lon_m_s1 <= lon_a;
			lon_m_s2 <= lon_m_s1;
		end
	end

	// parametric angle
	assign side2 = '{pk: pk_m_s2, zk: zk_m, lon: lon_m_s2};

	e2g_vec u_vec_q (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.vin      (v_m_s2),
		.xin      (pb_m),
		.yin      (zk_m),
		.side_in  (side2),
		.vout     (v_q),
		.len      (),
		.ang      (q_ang),
		.side_out (q_side)
	);

	// rotation cordic for cos q and sin q
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_s <= '0;
		end else if (en) begin
			rv_s <= {rv_s[N-1:0], v_q};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rx_s[0]  <= INV_K_Q30;
			ry_s[0]  <= '0;
			ra_s[0]  <= q_ang;
			rsd_s[0] <= q_side;
			for (int i = 0; i < N; i++) begin
				if (!ra_s[i][AW-1]) begin
					rx_s[i+1] <= rx_s[i] - (ry_s[i] >>> i);
					ry_s[i+1] <= ry_s[i] + (rx_s[i] >>> i);
					ra_s[i+1] <= ra_s[i] - ATAN_TAB[i];
				end else begin
					rx_s[i+1] <= rx_s[i] + (ry_s[i] >>> i);
					ry_s[i+1] <= ry_s[i] - (rx_s[i] >>> i);
					ra_s[i+1] <= ra_s[i] + ATAN_TAB[i];
				end
				rsd_s[i+1] <= rsd_s[i];
			end
		end
	end

	// cubes of cos q and sin q in q30
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_c_s1 <= 1'b0;
			v_c_s2 <= 1'b0;
		end else if (en) begin
			v_c_s1 <= rv_s[N];
			v_c_s2 <= v_c_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sqc_s1  <= rx_s[N] * rx_s[N];
			sqs_s1  <= ry_s[N] * ry_s[N];
			c_s1    <= rx_s[N];
			s_s1    <= ry_s[N];
			sd_c_s1 <= rsd_s[N];
			tc_s2   <= (RW + 2)'(sqc_s1 >>> QB) * c_s1;
			ts_s2   <= (RW + 2)'(sqs_s1 >>> QB) * s_s1;
			sd_c_s2 <= sd_c_s1;
		end
	end

	assign cube_c = coef_t'(tc_s2 >>> QB);
	assign cube_s = coef_t'(ts_s2 >>> QB);

	// ellipsoid corrections
	e2g_mulq u_mul_ca (.clk(clk), .en(en), .a(CORR_A), .b(cube_c), .p(ma));
	e2g_mulq u_mul_cb (.clk(clk), .en(en), .a(CORR_B), .b(cube_s), .p(mb));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_n_s1 <= 1'b0;
			v_n_s2 <= 1'b0;
			v_d_s1 <= 1'b0;
		end else if (en) begin
			v_n_s1 <= v_c_s2;
			v_n_s2 <= v_n_s1;
			v_d_s1 <= v_n_s2;
		end
	end

	// numerator and denominator of the latitude
	always_ff @(posedge clk) begin
		if (en) begin
			sd_n_s1  <= sd_c_s2;
			sd_n_s2  <= sd_n_s1;
			num_s1   <= sd_n_s2.zk + mb;
			den_s1   <= sd_n_s2.pk - ma;
			lon_d_s1 <= sd_n_s2.lon;
		end
	end

	assign side3 = '{pk: '0, zk: '0, lon: lon_d_s1};

	e2g_vec u_vec_lat (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.vin      (v_d_s1),
		.xin      (den_s1),
		.yin      (num_s1),
		.side_in  (side3),
		.vout     (v_l),
		.len      (),
		.ang      (lat_ang),
		.side_out (sl)
	);

	// degrees, rounded and saturated
	assign res.lat = LAT_W'(to_deg(lat_ang, LAT_LIM64));
	assign res.lon = LON_W'(to_deg(sl.lon, LON_LIM64));

	// two-entry output buffer
	assign push = en && v_l;
	assign pop  = m_tvalid && m_tready;
	assign m_tvalid = (cnt_q != 2'd0);
	assign m_tdata = {7'b0, buf0_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (cnt_q == 2'd0 || (cnt_q == 2'd1 && pop)) begin
			if (push) buf0_q <= res;
		end else if (cnt_q == 2'd2 && pop) begin
			buf0_q <= buf1_q;
		end
		if (push && ((cnt_q == 2'd1 && !pop) || cnt_q == 2'd2)) begin
			buf1_q <= res;
		end
	end

	// checks
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("output buffer count out of range");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2 && !m_tready) |-> !s_tready)
		else $error("request taken while output buffer full");

	a_lat_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (buf0_q.lat <= LAT_LIM && buf0_q.lat >= -LAT_LIM))
		else $error("latitude beyond the pole");

	a_lon_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (buf0_q.lon <= LON_LIM && buf0_q.lon >= -LON_LIM))
		else $error("longitude beyond half turn");

endmodule

// File: rtl/e2g_mulq.sv
module e2g_mulq (
	input  logic          clk,
	input  logic          en,
	input  e2g_pkg::data_t a,
	input  e2g_pkg::coef_t b,
	output e2g_pkg::data_t p
);
	import e2g_pkg::*;

	localparam int HI_W = DW - QB;
	localparam int SUM_W = HI_W + BW + 1;

	logic [DW-1:0]        ua;
	logic [BW-1:0]        ub;
	logic [HI_W+BW-1:0]   hi_s1;
	logic [QB+BW-1:0]     lo_s1;
	logic                 neg_s1;
	logic [SUM_W-1:0]     sum;

	// magnitudes
	assign ua = a[DW-1] ? -a : a;
	assign ub = b[BW-1] ? -b : b;

	// two partial products of the magnitude
	always_ff @(posedge clk) begin
		if (en) begin
			hi_s1  <= ua[DW-1:QB] * ub;
			lo_s1  <= ua[QB-1:0] * ub;
			neg_s1 <= a[DW-1] ^ b[BW-1];
		end
	end

	// recombine, floor, apply sign
	assign sum = SUM_W'(hi_s1) + SUM_W'(lo_s1 >> QB);

	always_ff @(posedge clk) begin
		if (en) begin
			p <= neg_s1 ? -data_t'(sum) : data_t'(sum);
		end
	end

endmodule

// File: rtl/e2g_vec.sv
module e2g_vec (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           vin,
	input  e2g_pkg::data_t xin,
	input  e2g_pkg::data_t yin,
	input  e2g_pkg::side_t side_in,
	output logic           vout,
	output e2g_pkg::data_t len,
	output e2g_pkg::ang_t  ang,
	output e2g_pkg::side_t side_out
);
	import e2g_pkg::*;

	localparam int N = CORDIC_STAGES;
	localparam ang_t HALF_TURN = ang_t'(64'd4 << UNIT_BITS);

	logic [N:0] v_s;
	logic [N:0] zr_s;
	data_t      x_s [0:N];
	data_t      y_s [0:N];
	ang_t       z_s [0:N];
	side_t      sd_s [0:N];

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[N-1:0], vin};
		end
	end

	// left half-plane fold, then one micro-rotation per stage
	always_ff @(posedge clk) begin
		if (en) begin
			zr_s <= {zr_s[N-1:0], (xin == '0 && yin == '0)};
			sd_s[0] <= side_in;
			if (xin[DW-1]) begin
				x_s[0] <= -xin;
				y_s[0] <= -yin;
				z_s[0] <= yin[DW-1] ? -HALF_TURN : HALF_TURN;
			end else begin
				x_s[0] <= xin;
				y_s[0] <= yin;
				z_s[0] <= '0;
			end
			for (int i = 0; i < N; i++) begin
				if (!y_s[i][DW-1]) begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + ATAN_TAB[i];
				end else begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - ATAN_TAB[i];
				end
				sd_s[i+1] <= sd_s[i];
			end
		end
	end

	// zero vector gives zero angle and length
	assign vout     = v_s[N];
	assign len      = zr_s[N] ? '0 : x_s[N];
	assign ang      = zr_s[N] ? '0 : z_s[N];
	assign side_out = sd_s[N];

endmodule
